/* hw/rtl/bse_pkg.sv */
// Shared types and constants for the bitonic sort engine.
package bse_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned SET_SIZE_DEF = 64;
  localparam logic [KEY_W-1:0] PAD_KEY = {KEY_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_EMIT_RD,
    ST_EMIT
  } bse_state_t;

endpackage

/* hw/rtl/bse_key_ram.sv */
// Key store: one write port, two registered read ports.
module bse_key_ram
  import bse_pkg::*;
#(
  parameter int unsigned DEPTH = SET_SIZE_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [KEY_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr_a,
  input  logic [AW-1:0]           raddr_b,
  output logic signed [KEY_W-1:0] rdata_a,
  output logic signed [KEY_W-1:0] rdata_b
);

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hw/rtl/bse_cmp_swap.sv */
// Compare-exchange unit: orders a pair of signed keys up or down.
module bse_cmp_swap
  import bse_pkg::*;
(
  input  logic signed [KEY_W-1:0] key_a,
  input  logic signed [KEY_W-1:0] key_b,
  input  logic                    up,
  output logic                    swap,
  output logic signed [KEY_W-1:0] first,
  output logic signed [KEY_W-1:0] second
);

  always_comb begin
    swap   = up ? (key_b < key_a) : (key_a < key_b);
    first  = swap ? key_b : key_a;
    second = swap ? key_a : key_b;
  end

endmodule

/* hw/rtl/bitonic_sort_engine.sv */
// Top level of the bitonic sort engine: sequencer, key store and compare unit.
// Keys arrive one per request on the slave side and are written to the key
// store. A request with tlast set, or the SET_SIZE-th key, closes the set: any
// slots not loaded are filled with -1, then the set is
// sorted ascending by a single compare-exchange unit working over the key
// store in SET_SIZE/2 * L*(L+1)/2 compare steps (L = log2 SET_SIZE), 672 for
// 64 keys. Each step reads its pair, then compares; a swapped pair takes a
// further write state, since the store has one write port. The sorted keys
// then leave on the master side, each read from the store before it is
// offered, the final one with tlast set, after which the next set may load.
// No input is taken while a set is padded, sorted or emitted.
module bitonic_sort_engine
  import bse_pkg::*;
#(
  parameter int unsigned SET_SIZE = SET_SIZE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic signed [KEY_W-1:0] s_tdata,   // [31:0] value
  input  logic                    s_tlast,   // last_in
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic signed [KEY_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                    m_tlast    // last_out
);

  localparam int unsigned AW   = $clog2(SET_SIZE);
  localparam int unsigned SW   = $clog2(AW + 1);
  localparam int unsigned CW   = AW + 1;
  localparam logic [CW-1:0] SET_CNT  = CW'(SET_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(SET_SIZE - 1);
  localparam logic [AW-1:0] LAST_PAIR = AW'(SET_SIZE / 2 - 1);
  localparam logic [SW-1:0] LAST_STAGE = SW'(AW - 1);

  bse_state_t state, state_next;

  logic [CW-1:0] load_count;
  logic [CW-1:0] cnt_inc;
  logic [SW-1:0] stage;     // block size is 2 << stage
  logic [SW-1:0] dist_exp;  // partner distance is 1 << dist_exp
  logic [AW-1:0] pair;
  logic [AW-1:0] emit_idx;

  logic [AW-1:0] idx_lo, idx_hi, low_mask;
  logic          up;
  logic          s_acc, m_acc, closing, pair_done;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr_a, ram_raddr_b;
  logic signed [KEY_W-1:0] ram_wdata, rd_a, rd_b;
  logic                    swap;
  logic signed [KEY_W-1:0] first, second;

  assign s_acc   = s_tvalid && s_tready;
  assign m_acc   = m_tvalid && m_tready;
  assign cnt_inc = load_count + CW'(1);
  assign closing = s_tlast || (cnt_inc == SET_CNT);
  assign pair_done = (pair == LAST_PAIR);

  // Insert a zero at bit dist_exp of the pair index to get the lower slot.
  always_comb begin
    low_mask = (AW'(1) << dist_exp) - AW'(1);
    idx_lo   = (((pair >> dist_exp) << dist_exp) << 1) | (pair & low_mask);
    idx_hi   = idx_lo | (AW'(1) << dist_exp);
    if (stage == LAST_STAGE) begin
      up = 1'b1;
    end else begin
      up = !idx_lo[stage + SW'(1)];
    end
  end

  bse_key_ram #(
    .DEPTH (SET_SIZE)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  bse_cmp_swap u_cmp (
    .key_a  (rd_a),
    .key_b  (rd_b),
    .up     (up),
    .swap   (swap),
    .first  (first),
    .second (second)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_acc && closing) begin
          state_next = (cnt_inc == SET_CNT) ? ST_SORT_RD : ST_PAD;
        end
      end
      ST_PAD: begin
        if (load_count[AW-1:0] == LAST_IDX) begin
          state_next = ST_SORT_RD;
        end
      end
      ST_SORT_RD: state_next = ST_SORT_CMP;
      ST_SORT_CMP, ST_SORT_WR: begin
        if (state == ST_SORT_CMP && swap) begin
          state_next = ST_SORT_WR;
        end else if (pair_done && dist_exp == '0 && stage == LAST_STAGE) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_SORT_RD;
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_acc) begin
          state_next = (emit_idx == LAST_IDX) ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs and store control.
  always_comb begin
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    m_tdata     = rd_a;
    m_tlast     = (emit_idx == LAST_IDX);
    ram_we      = 1'b0;
    ram_waddr   = load_count[AW-1:0];
    ram_wdata   = s_tdata;
    ram_re      = 1'b0;
    ram_raddr_a = idx_lo;
    ram_raddr_b = idx_hi;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid;
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = PAD_KEY;
      end
      ST_SORT_RD: ram_re = 1'b1;
      ST_SORT_CMP: begin
        ram_we    = swap;
        ram_waddr = idx_lo;
        ram_wdata = first;
      end
      ST_SORT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_hi;
        ram_wdata = second;
      end
      ST_EMIT_RD: begin
        ram_re      = 1'b1;
        ram_raddr_a = emit_idx;
      end
      ST_EMIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      stage      <= '0;
      dist_exp   <= '0;
      pair       <= '0;
      emit_idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (s_acc) begin
            load_count <= cnt_inc;
            stage      <= '0;
            dist_exp   <= '0;
            pair       <= '0;
          end
        end
        ST_PAD: load_count <= cnt_inc;
        ST_SORT_CMP, ST_SORT_WR: begin
          // Advance to the next pair unless the swap still needs its second write.
          if (!(state == ST_SORT_CMP && swap)) begin
            if (pair_done) begin
              pair <= '0;
              if (dist_exp == '0) begin
                if (stage == LAST_STAGE) begin
                  emit_idx <= '0;
                end else begin
                  stage    <= stage + SW'(1);
                  dist_exp <= stage + SW'(1);
                end
              end else begin
                dist_exp <= dist_exp - SW'(1);
              end
            end else begin
              pair <= pair + AW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (m_acc) begin
            emit_idx <= emit_idx + AW'(1);
            if (emit_idx == LAST_IDX) begin
              load_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the bitonic sort engine: directed and random key sets in, sorted runs checked.
module testbench;
  import bse_pkg::*;

  localparam int unsigned SET = SET_SIZE_DEF;
  localparam int unsigned RANDOM_KEYS = 460;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SRC_GAPS,
    PH_SINK_STALLS,
    PH_BOTH_IDLE
  } idle_phase_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic                    last;
    idle_phase_t             phase;
  } key_req_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } sorted_key_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic signed [KEY_W-1:0] s_tdata = '0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic signed [KEY_W-1:0] m_tdata;
  logic                    m_tlast;

  key_req_t    key_reqs[$];
  sorted_key_t sorted_due[$];

  // Predictor copy of the key set being loaded
  logic signed [KEY_W-1:0] set_keys [SET];
  int unsigned             keys_loaded = 0;

  idle_phase_t active_phase = PH_STEADY;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned cycle_limit = 32'hFFFF_FFFF;
  int unsigned set_count = 0;
  int unsigned key_count = 0;

  bitonic_sort_engine #(
    .SET_SIZE(SET)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic src_gap(idle_phase_t ph);
    if (ph == PH_SRC_GAPS) return $urandom_range(0, 99) < 70;
    if (ph == PH_BOTH_IDLE) return $urandom_range(0, 99) < 7;
    return 1'b0;
  endfunction

  function automatic logic sink_stall(idle_phase_t ph);
    if (ph == PH_SINK_STALLS) return $urandom_range(0, 99) < 70;
    if (ph == PH_BOTH_IDLE) return $urandom_range(0, 99) < 7;
    return 1'b0;
  endfunction

  // Store one key; on a closed set pad, run the bitonic network, queue the sorted run
  task automatic load_key(input logic signed [KEY_W-1:0] key, input logic last);
    int unsigned             blk;
    int unsigned             gap;
    int unsigned             partner;
    logic                    up;
    logic signed [KEY_W-1:0] a;
    logic signed [KEY_W-1:0] b;
    sorted_key_t             res;
    set_keys[keys_loaded] = key;
    keys_loaded++;
    if (!last && keys_loaded < SET) return;
    for (int unsigned i = keys_loaded; i < SET; i++) set_keys[i] = PAD_KEY;
    for (blk = 2; blk <= SET; blk = blk << 1) begin
      for (gap = blk >> 1; gap > 0; gap = gap >> 1) begin
        for (int unsigned i = 0; i < SET; i++) begin
          partner = i ^ gap;
          if (partner > i && partner < SET) begin
            up = (i & blk) == 0;
            a = set_keys[i];
            b = set_keys[partner];
            if (up ? (b < a) : (a < b)) begin
              set_keys[i] = b;
              set_keys[partner] = a;
            end
          end
        end
      end
    end
    for (int unsigned i = 0; i < SET; i++) begin
      res.key = set_keys[i];
      res.last = (i == SET - 1);
      sorted_due.insert(sorted_due.size(), res);
    end
    keys_loaded = 0;
  endtask

  // Driver: present pending requests, hold while the engine back-pressures
  always @(posedge clk) begin
    key_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) load_key(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (key_reqs.size() != 0 && !src_gap(key_reqs[0].phase)) begin
          req = key_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= req.key;
          s_tlast <= req.last;
          active_phase <= req.phase;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each sorted key against the oldest expectation
  always @(posedge clk) begin
    sorted_key_t exp_key;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected key: expected none, actual %0d last %0b",
                   $time, m_tdata, m_tlast);
          mismatch_count++;
        end else begin
          exp_key = sorted_due.pop_front();
          if (m_tdata !== exp_key.key) begin
            $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                     $time, exp_key.key, m_tdata);
            mismatch_count++;
          end
          if (m_tlast !== exp_key.last) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, exp_key.last, m_tlast);
            mismatch_count++;
          end
        end
      end
      m_tready <= !sink_stall(active_phase);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= cycle_limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_key(input logic signed [KEY_W-1:0] key, input logic last,
                          input idle_phase_t ph);
    key_req_t req;
    req.key = key;
    req.last = last;
    req.phase = ph;
    key_reqs.insert(key_reqs.size(), req);
    key_count++;
    if (last) set_count++;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return PAD_KEY;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned len;
    int unsigned random_keys;
    logic        last;
    idle_phase_t ph;

    // One key: the rest of the set is padding
    push_key(32'sh7FFF_FFFF, 1'b1, PH_STEADY);
    // Field extremes, sign boundary, pad collisions and duplicates
    push_key(32'sh8000_0000, 1'b0, PH_STEADY);
    push_key(32'sh7FFF_FFFF, 1'b0, PH_STEADY);
    push_key(0, 1'b0, PH_STEADY);
    push_key(-1, 1'b0, PH_STEADY);
    push_key(1, 1'b0, PH_STEADY);
    push_key(-2, 1'b0, PH_STEADY);
    push_key(32'sh8000_0000, 1'b0, PH_STEADY);
    push_key(5, 1'b1, PH_STEADY);
    // Equal keys
    push_key(3, 1'b0, PH_STEADY);
    push_key(3, 1'b0, PH_STEADY);
    push_key(3, 1'b0, PH_STEADY);
    push_key(-1, 1'b1, PH_STEADY);
    push_key(32'sh8000_0001, 1'b0, PH_STEADY);
    push_key(32'sh7FFF_FFFE, 1'b1, PH_STEADY);

    // Random sets: mostly short, some near-full and full ones
    random_keys = 0;
    while (random_keys < RANDOM_KEYS) begin
      case ($urandom_range(0, 9))
        0: len = SET;
        1: len = $urandom_range(SET / 2 + 1, SET - 1);
        default: len = $urandom_range(1, 16);
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        ph = idle_phase_t'((random_keys * 4) / RANDOM_KEYS > 3 ? 3
                           : (random_keys * 4) / RANDOM_KEYS);
        // A full set closes on its own; tlast there is random
        if (len == SET && i == len - 1) last = $urandom_range(0, 1);
        else last = (i == len - 1);
        push_key(pick_key(), last, ph);
        if (len == SET && i == len - 1 && !last) set_count++;
        random_keys++;
      end
    end

    cycle_limit = 10000 + set_count * 12000 + key_count * 40;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (key_reqs.size() != 0 || s_tvalid || sorted_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
